/* hdl/sbbb_pkg.sv */
// Package for the segment band bounding box: register indexes, field widths
// and reset values used by the top level and the divider cell. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sbbb_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 32;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 31;
  localparam int unsigned BAND_W     = 31;
  localparam int unsigned PAD_W      = 31;
  localparam int unsigned EPS_W      = 16;

  // Extents never exceed end_pad + band_width/2 + 1, so 32 quotient bits do.
  localparam int unsigned QUOT_W = 32;

  localparam logic [BAND_W-1:0] BAND_RESET = BAND_W'(65536);
  localparam logic [PAD_W-1:0]  PAD_RESET  = '0;
  localparam logic [EPS_W-1:0]  EPS_RESET  = EPS_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BAND_WIDTH   = 2'd0,
    REG_END_PAD      = 2'd1,
    REG_AXIS_EPSILON = 2'd2
  } cfg_reg_e;

endpackage

`default_nettype wire

/* hdl/segment_band_bounding_box.sv */
// Top level of the segment band bounding box: input, difference, product and sum stages,
// a chain of sbbb_sqrt_cell, stage E, a chain of sbbb_div_cell and an output stage. Depends on sbbb_pkg.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one request per clock cycle whenever start_i is high; busy_o
// stays low, so requests may follow each other back to back. Each result
// appears on done_o for exactly one cycle, after it has passed the four entry
// stages, one square-root cell per root bit, one normalize stage, one divider
// cell per quotient bit and the output register. The receiver cannot stall
// the results, so it must take them as they come. Configuration writes are
// taken at any time but must only be issued while no request is in flight.
module segment_band_bounding_box
  import sbbb_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic signed [COORD_WIDTH-1:0] a_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] a_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] b_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] b_y_i,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data_i,
  output logic                               done_o,
  output logic signed [COORD_WIDTH+3:0]      origin_x_o,
  output logic signed [COORD_WIDTH+3:0]      origin_y_o,
  output logic [COORD_WIDTH+3:0]             box_width_o,
  output logic [COORD_WIDTH+3:0]             box_height_o,
  output logic                               axis_aligned_o
);

  localparam int unsigned W   = COORD_WIDTH;
  localparam int unsigned OW  = W + 4;
  localparam int unsigned LW  = W + 1;
  localparam int unsigned SW  = 2 * W + 1;
  localparam int unsigned NW  = W + 33;
  localparam int unsigned DW  = LW + 1;
  localparam int unsigned XW  = W + QUOT_W + 4;
  localparam int unsigned DP  = 2 + 6 * W;
  localparam int unsigned SP  = DP + 2 * NW;
  localparam int unsigned LAT = LW + QUOT_W + 6;

  // Configuration registers.
  logic [BAND_W-1:0] band_q;
  logic [PAD_W-1:0]  pad_q;
  logic [EPS_W-1:0]  eps_q;
  logic              accept;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_q <= BAND_RESET;
      pad_q  <= PAD_RESET;
      eps_q  <= EPS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_BAND_WIDTH:   band_q <= cfg_data_i[BAND_W-1:0];
        REG_END_PAD:      pad_q  <= cfg_data_i[PAD_W-1:0];
        REG_AXIS_EPSILON: eps_q  <= cfg_data_i[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage A: input register.
  logic a_vld_q;
  logic signed [W-1:0] a_ax_q, a_ay_q, a_bx_q, a_by_q;

  // Stage B: differences.
  logic signed [W:0] dx, dy;
  logic b_vld_q;
  logic [W-1:0] b_adx_q, b_ady_q;
  logic signed [W-1:0] b_ax_q, b_ay_q, b_minx_q, b_miny_q;

  // Stage C: products.
  logic c_vld_q, c_flag_q;
  logic [2*W-1:0] c_sqx_q, c_sqy_q;
  logic [W+31:0]  c_pxa_q, c_pya_q;
  logic [W+30:0]  c_pxb_q, c_pyb_q;
  logic [W-1:0]   c_adx_q, c_ady_q;
  logic signed [W-1:0] c_ax_q, c_ay_q, c_minx_q, c_miny_q;

  // Stage D: sums.
  logic d_vld_q, d_flag_q, d_coinc;
  logic [SW-1:0] d_s_q;
  logic [NW-1:0] d_nx_q, d_ny_q;
  logic [W-1:0]  d_adx_q, d_ady_q;
  logic signed [W-1:0] d_ax_q, d_ay_q, d_minx_q, d_miny_q;
  logic [2*EPS_W-1:0] eps_sq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
    end else begin
      a_vld_q <= accept;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
    end
  end

  always_comb begin
    dx = $signed({a_bx_q[W-1], a_bx_q}) - $signed({a_ax_q[W-1], a_ax_q});
    dy = $signed({a_by_q[W-1], a_by_q}) - $signed({a_ay_q[W-1], a_ay_q});
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_ax_q <= a_x_i;
      a_ay_q <= a_y_i;
      a_bx_q <= b_x_i;
      a_by_q <= b_y_i;
    end
    b_adx_q  <= dx[W] ? W'(-dx) : dx[W-1:0];
    b_ady_q  <= dy[W] ? W'(-dy) : dy[W-1:0];
    b_ax_q   <= a_ax_q;
    b_ay_q   <= a_ay_q;
    b_minx_q <= (a_ax_q < a_bx_q) ? a_ax_q : a_bx_q;
    b_miny_q <= (a_ay_q < a_by_q) ? a_ay_q : a_by_q;

    c_sqx_q  <= (2*W)'(b_adx_q) * (2*W)'(b_adx_q);
    c_sqy_q  <= (2*W)'(b_ady_q) * (2*W)'(b_ady_q);
    c_pxa_q  <= (W+32)'(b_adx_q) * (W+32)'({pad_q, 1'b0});
    c_pya_q  <= (W+32)'(b_ady_q) * (W+32)'({pad_q, 1'b0});
    c_pxb_q  <= (W+31)'(b_adx_q) * (W+31)'(band_q);
    c_pyb_q  <= (W+31)'(b_ady_q) * (W+31)'(band_q);
    c_flag_q <= ((W+EPS_W)'(b_adx_q) < (W+EPS_W)'(eps_q)) ||
                ((W+EPS_W)'(b_ady_q) < (W+EPS_W)'(eps_q));
    c_adx_q  <= b_adx_q;
    c_ady_q  <= b_ady_q;
    c_ax_q   <= b_ax_q;
    c_ay_q   <= b_ay_q;
    c_minx_q <= b_minx_q;
    c_miny_q <= b_miny_q;

    d_s_q    <= SW'(c_sqx_q) + SW'(c_sqy_q);
    d_nx_q   <= NW'(c_pxa_q) + NW'(c_pyb_q);
    d_ny_q   <= NW'(c_pya_q) + NW'(c_pxb_q);
    d_flag_q <= c_flag_q;
    d_adx_q  <= c_adx_q;
    d_ady_q  <= c_ady_q;
    d_ax_q   <= c_ax_q;
    d_ay_q   <= c_ay_q;
    d_minx_q <= c_minx_q;
    d_miny_q <= c_miny_q;
  end

  always_comb begin
    eps_sq  = (2*EPS_W)'(eps_q) * (2*EPS_W)'(eps_q);
    d_coinc = (d_s_q == '0) || ((SW+2*EPS_W)'(d_s_q) < (SW+2*EPS_W)'(eps_sq));
  end

  // Square-root chain.
  logic          sq_vld  [LW+1];
  logic [2*LW-1:0] sq_rad [LW+1];
  logic [LW+1:0] sq_rem  [LW+1];
  logic [LW-1:0] sq_root [LW+1];
  logic [SP-1:0] sq_pass [LW+1];

  assign sq_vld[0]  = d_vld_q;
  assign sq_rad[0]  = (2*LW)'(d_s_q);
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_pass[0] = {d_nx_q, d_ny_q, d_coinc, d_flag_q, d_adx_q, d_ady_q,
                       d_ax_q, d_ay_q, d_minx_q, d_miny_q};

  for (genvar k = 0; k < LW; k++) begin : g_sqrt
    sbbb_sqrt_cell #(.LW(LW), .PW(SP)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (sq_vld[k]),
      .rad_i  (sq_rad[k]),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .pass_i (sq_pass[k]),
      .vld_o  (sq_vld[k+1]),
      .rad_o  (sq_rad[k+1]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_root[k+1]),
      .pass_o (sq_pass[k+1])
    );
  end

  // Stage E: add the rounding term and form the divisor 2L.
  logic          e_vld_q;
  logic [NW-1:0] e_nx_q, e_ny_q;
  logic [DW-1:0] e_d_q;
  logic [DP-1:0] e_pass_q;
  logic [NW-1:0] sq_nx, sq_ny;

  assign sq_nx = sq_pass[LW][SP-1 -: NW];
  assign sq_ny = sq_pass[LW][SP-NW-1 -: NW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else begin
      e_vld_q <= sq_vld[LW];
    end
  end

  always_ff @(posedge clk_i) begin
    e_nx_q   <= sq_nx + NW'(sq_root[LW]);
    e_ny_q   <= sq_ny + NW'(sq_root[LW]);
    e_d_q    <= {sq_root[LW], 1'b0};
    e_pass_q <= sq_pass[LW][DP-1:0];
  end

  // Divider chain, most significant quotient bit first.
  logic          dv_vld [QUOT_W+1];
  logic [NW-1:0] dv_rx  [QUOT_W+1];
  logic [NW-1:0] dv_ry  [QUOT_W+1];
  logic [DW-1:0] dv_d   [QUOT_W+1];
  logic [QUOT_W-1:0] dv_qx [QUOT_W+1];
  logic [QUOT_W-1:0] dv_qy [QUOT_W+1];
  logic [DP-1:0] dv_pass [QUOT_W+1];

  assign dv_vld[0]  = e_vld_q;
  assign dv_rx[0]   = e_nx_q;
  assign dv_ry[0]   = e_ny_q;
  assign dv_d[0]    = e_d_q;
  assign dv_qx[0]   = '0;
  assign dv_qy[0]   = '0;
  assign dv_pass[0] = e_pass_q;

  for (genvar i = 0; i < QUOT_W; i++) begin : g_div
    sbbb_div_cell #(.NW(NW), .DW(DW), .SH(QUOT_W - 1 - i), .PW(DP)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (dv_vld[i]),
      .rx_i   (dv_rx[i]),
      .ry_i   (dv_ry[i]),
      .d_i    (dv_d[i]),
      .qx_i   (dv_qx[i]),
      .qy_i   (dv_qy[i]),
      .pass_i (dv_pass[i]),
      .vld_o  (dv_vld[i+1]),
      .rx_o   (dv_rx[i+1]),
      .ry_o   (dv_ry[i+1]),
      .d_o    (dv_d[i+1]),
      .qx_o   (dv_qx[i+1]),
      .qy_o   (dv_qy[i+1]),
      .pass_o (dv_pass[i+1])
    );
  end

  // Output stage.
  logic                f_coinc, f_flag;
  logic [W-1:0]        f_adx, f_ady;
  logic signed [W-1:0] f_ax, f_ay, f_minx, f_miny;
  logic [XW-1:0]       ox, oy, bw_x, bw_y, half;
  logic                out_vld_q, out_coinc_q, out_flag_q;
  logic [OW-1:0]       out_ox_q, out_oy_q, out_w_q, out_h_q;

  assign {f_coinc, f_flag, f_adx, f_ady, f_ax, f_ay, f_minx, f_miny} =
    dv_pass[QUOT_W];

  always_comb begin
    half = XW'(band_q[BAND_W-1:1]);
    if (f_coinc) begin
      ox   = XW'(f_ax) - half;
      oy   = XW'(f_ay) - half;
      bw_x = XW'(band_q);
      bw_y = XW'(band_q);
    end else begin
      ox   = XW'(f_minx) - XW'(dv_qx[QUOT_W]);
      oy   = XW'(f_miny) - XW'(dv_qy[QUOT_W]);
      bw_x = XW'(f_adx) + (XW'(dv_qx[QUOT_W]) << 1);
      bw_y = XW'(f_ady) + (XW'(dv_qy[QUOT_W]) << 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= dv_vld[QUOT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    out_ox_q    <= ox[OW-1:0];
    out_oy_q    <= oy[OW-1:0];
    out_w_q     <= bw_x[OW-1:0];
    out_h_q     <= bw_y[OW-1:0];
    out_coinc_q <= f_coinc;
    out_flag_q  <= f_coinc || f_flag;
  end

  assign done_o         = out_vld_q;
  assign origin_x_o     = $signed(out_ox_q);
  assign origin_y_o     = $signed(out_oy_q);
  assign box_width_o    = out_w_q;
  assign box_height_o   = out_h_q;
  assign axis_aligned_o = out_flag_q;

  // Every accepted request produces a result on done_o.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LAT done_o)
    else $error("result missing at expected latency");

  // Coincident anchors give a square box with the flag set.
  a_coinc_square: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_coinc_q) |-> (box_width_o == box_height_o && axis_aligned_o))
    else $error("coincident result is not a flagged square");

endmodule

`default_nettype wire

/* hdl/sbbb_sqrt_cell.sv */
// One cell of the square-root chain: resolves one root bit per cycle and
// hands remainder, partial root and the request's other data to the next cell.
`timescale 1ns / 1ps
`default_nettype none

module sbbb_sqrt_cell #(
  parameter int unsigned LW = 33,
  parameter int unsigned PW = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            vld_i,
  input  wire logic [2*LW-1:0] rad_i,
  input  wire logic [LW+1:0]   rem_i,
  input  wire logic [LW-1:0]   root_i,
  input  wire logic [PW-1:0]   pass_i,
  output logic                 vld_o,
  output logic [2*LW-1:0]      rad_o,
  output logic [LW+1:0]        rem_o,
  output logic [LW-1:0]        root_o,
  output logic [PW-1:0]        pass_o
);

  logic [LW+3:0] cur, sub, diff;
  logic          take;
  logic          vld_q;
  logic [2*LW-1:0] rad_q;
  logic [LW+1:0]   rem_q;
  logic [LW-1:0]   root_q;
  logic [PW-1:0]   pass_q;

  always_comb begin
    cur  = {rem_i, rad_i[2*LW-1 -: 2]};
    sub  = {2'b00, root_i, 2'b01};
    diff = cur - sub;
    take = (cur >= sub);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= {rad_i[2*LW-3:0], 2'b00};
    rem_q  <= take ? diff[LW+1:0] : cur[LW+1:0];
    root_q <= {root_i[LW-2:0], take};
    pass_q <= pass_i;
  end

  assign vld_o  = vld_q;
  assign rad_o  = rad_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign pass_o = pass_q;

endmodule

`default_nettype wire

/* hdl/sbbb_div_cell.sv */
// One cell of the divider chain: resolves one quotient bit of both extents
// per cycle against the shared divisor. Depends on sbbb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbbb_div_cell
  import sbbb_pkg::*;
#(
  parameter int unsigned NW = 65,
  parameter int unsigned DW = 34,
  parameter int unsigned SH = 0,
  parameter int unsigned PW = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          vld_i,
  input  wire logic [NW-1:0] rx_i,
  input  wire logic [NW-1:0] ry_i,
  input  wire logic [DW-1:0] d_i,
  input  wire logic [QUOT_W-1:0] qx_i,
  input  wire logic [QUOT_W-1:0] qy_i,
  input  wire logic [PW-1:0] pass_i,
  output logic               vld_o,
  output logic [NW-1:0]      rx_o,
  output logic [NW-1:0]      ry_o,
  output logic [DW-1:0]      d_o,
  output logic [QUOT_W-1:0]  qx_o,
  output logic [QUOT_W-1:0]  qy_o,
  output logic [PW-1:0]      pass_o
);

  localparam int unsigned CW = NW + DW + SH;

  logic [CW-1:0] dsh, ex, ey;
  logic          tx, ty;
  logic          vld_q;
  logic [NW-1:0] rx_q, ry_q;
  logic [DW-1:0] d_q;
  logic [QUOT_W-1:0] qx_q, qy_q;
  logic [PW-1:0] pass_q;

  always_comb begin
    dsh = CW'(d_i) << SH;
    ex  = CW'(rx_i);
    ey  = CW'(ry_i);
    tx  = (ex >= dsh);
    ty  = (ey >= dsh);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rx_q   <= tx ? NW'(ex - dsh) : rx_i;
    ry_q   <= ty ? NW'(ey - dsh) : ry_i;
    qx_q   <= {qx_i[QUOT_W-2:0], tx};
    qy_q   <= {qy_i[QUOT_W-2:0], ty};
    d_q    <= d_i;
    pass_q <= pass_i;
  end

  assign vld_o  = vld_q;
  assign rx_o   = rx_q;
  assign ry_o   = ry_q;
  assign d_o    = d_q;
  assign qx_o   = qx_q;
  assign qy_o   = qy_q;
  assign pass_o = pass_q;

endmodule

`default_nettype wire
